/* src/gated_running_median_filter_assert.svh */
// assertion macros shared by the filter rtl
// no dependencies; expects clk and rst_n in the including scope
`ifndef GATED_RUNNING_MEDIAN_FILTER_ASSERT_SVH
`define GATED_RUNNING_MEDIAN_FILTER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define GRMF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define GRMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/grmf_pkg.sv */
// shared types and constants for the gated running median filter
// no dependencies
package grmf_pkg;

    localparam int DATA_W = 24;
    localparam int TIME_W = 48;
    localparam int GAP_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam int WINDOW_DEFAULT = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT = 2'd2;

    // register reset values
    localparam logic signed [DATA_W-1:0] BAND_LOW_RST = -24'sd8388000;
    localparam logic signed [DATA_W-1:0] BAND_HIGH_RST = 24'sd8388000;
    localparam logic [GAP_W-1:0] GAP_LIMIT_RST = 32'd1000000;

    typedef struct packed {
        logic                     sample_present;
        logic signed [DATA_W-1:0] raw_sample;
        logic [TIME_W-1:0]        read_time_us;
    } grmf_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] median_value;
        logic                     accepted;
        logic                     saturated;
        logic                     window_cleared;
    } grmf_out_t;

endpackage

/* src/grmf_rank.sv */
// rank test of one window entry against all filled entries
// depends on grmf_pkg
module grmf_rank #(
    parameter int WINDOW = grmf_pkg::WINDOW_DEFAULT,
    parameter int CNT_W = $clog2(WINDOW + 1)
) (
    input  logic signed [grmf_pkg::DATA_W-1:0] entries [WINDOW],
    input  logic [CNT_W-1:0]                   fill,
    input  logic signed [grmf_pkg::DATA_W-1:0] candidate,
    output logic                               hit
);

    logic [CNT_W-1:0] less_cnt;
    logic [CNT_W-1:0] eq_cnt;
    logic [CNT_W-1:0] mid_rank;

    always_comb
    begin
        less_cnt = '0;
        eq_cnt = '0;
        for (int j = 0; j < WINDOW; j++)
        begin
            if (CNT_W'(j) < fill)
            begin
                if (entries[j] < candidate)
                begin
                    less_cnt = less_cnt + CNT_W'(1);
                end
                if (entries[j] == candidate)
                begin
                    eq_cnt = eq_cnt + CNT_W'(1);
                end
            end
        end
    end

    // upper median: sorted position fill/2
    assign mid_rank = fill >> 1;
    assign hit = (less_cnt <= mid_rank) && (mid_rank < less_cnt + eq_cnt);

endmodule

/* src/gated_running_median_filter.sv */
// top level of the gated running median filter: gating, window, median sequencer
// depends on grmf_pkg, grmf_rank and gated_running_median_filter_assert.svh
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+-----------------------------
//   sample   | in        | sample_valid/sample_stall | grmf_in_t  (present, sample, time)
//   result   | out       | result_valid/result_stall | grmf_out_t (median, flags)
//   cfg      | in        | cfg_valid/cfg_ready       | cfg_index, cfg_data
//
// an item passes through eval, then a median scan over up to fill count
// candidates, then emit (absent or rejected samples skip the scan). the shared rank
// unit checks one candidate per cycle, which sets the scan length.
// reset clears all control state; window entries are not reset and are only
// read below the fill count. a stalled result sits in the output register
// while the next sample is taken; the sequencer waits only if it must emit then.
`include "gated_running_median_filter_assert.svh"

module gated_running_median_filter #(
    parameter int WINDOW = grmf_pkg::WINDOW_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  grmf_pkg::grmf_in_t                  sample,
    output logic                                result_valid,
    input  logic                                result_stall,
    output grmf_pkg::grmf_out_t                 result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [grmf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [grmf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int DW = grmf_pkg::DATA_W;
    localparam int TW = grmf_pkg::TIME_W;
    localparam int GW = grmf_pkg::GAP_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,   // waiting for a sample transfer
        ST_EVAL = 4'b0010,   // band and gap checks, window write
        ST_SCAN = 4'b0100,   // one candidate per cycle through the rank unit
        ST_EMIT = 4'b1000    // load the result register
    } state_t;

    state_t state_reg, state_next;

    // captured sample
    grmf_pkg::grmf_in_t item_reg;

    // configuration
    logic signed [DW-1:0] band_low_reg, band_low_next;
    logic signed [DW-1:0] band_high_reg, band_high_next;
    logic [GW-1:0]        gap_limit_reg, gap_limit_next;

    // window bookkeeping
    logic signed [DW-1:0] entries_reg [WINDOW];
    logic [IDX_W-1:0]     wpos_reg, wpos_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic [TW-1:0]        last_time_reg, last_time_next;
    logic signed [DW-1:0] median_reg, median_next;

    // sequencer
    logic [IDX_W-1:0]     cand_reg, cand_next;
    logic                 acc_reg, acc_next;
    logic                 sat_reg, sat_next;
    logic                 clr_reg, clr_next;

    // output register
    logic                 result_valid_reg, result_valid_next;
    grmf_pkg::grmf_out_t  result_reg, result_next;

    // eval-cycle decisions
    logic                 in_band;
    logic                 take;
    logic                 gap_hit;
    logic [TW-1:0]        time_diff;
    logic [IDX_W-1:0]     wpos_eff;
    logic [CNT_W-1:0]     fill_eff;
    logic                 write_en;

    // scan
    logic signed [DW-1:0] cand_value;
    logic                 rank_hit;
    logic                 cand_last;
    logic                 emit_ok;

    assign sample_stall = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign result_valid = result_valid_reg;
    assign result = result_reg;

    // band test and gap test on the captured sample
    assign in_band = (item_reg.raw_sample > band_low_reg)
                  && (item_reg.raw_sample < band_high_reg);
    assign take = item_reg.sample_present && in_band;
    assign time_diff = item_reg.read_time_us - last_time_reg;
    assign gap_hit = (last_time_reg != '0)
                  && (item_reg.read_time_us > last_time_reg)
                  && (time_diff > {{(TW-GW){1'b0}}, gap_limit_reg});

    // a long gap restarts the window before this sample goes in
    assign wpos_eff = gap_hit ? '0 : wpos_reg;
    assign fill_eff = gap_hit ? '0 : fill_reg;
    assign write_en = (state_reg == ST_EVAL) && take;

    assign cand_value = entries_reg[cand_reg];
    assign cand_last = (cand_reg == IDX_W'(fill_reg - CNT_W'(1)));
    assign emit_ok = !result_valid_reg || !result_stall;

    grmf_rank #(
        .WINDOW (WINDOW),
        .CNT_W  (CNT_W)
    ) u_rank (
        .entries   (entries_reg),
        .fill      (fill_reg),
        .candidate (cand_value),
        .hit       (rank_hit)
    );

    // configuration writes
    always_comb
    begin
        band_low_next = band_low_reg;
        band_high_next = band_high_reg;
        gap_limit_next = gap_limit_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                grmf_pkg::CFG_BAND_LOW:  band_low_next = cfg_data[DW-1:0];
                grmf_pkg::CFG_BAND_HIGH: band_high_next = cfg_data[DW-1:0];
                grmf_pkg::CFG_GAP_LIMIT: gap_limit_next = cfg_data[GW-1:0];
                default:                 band_low_next = band_low_reg;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        wpos_next = wpos_reg;
        fill_next = fill_reg;
        last_time_next = last_time_reg;
        median_next = median_reg;
        cand_next = cand_reg;
        acc_next = acc_reg;
        sat_next = sat_reg;
        clr_next = clr_reg;
        result_next = result_reg;
        result_valid_next = result_valid_reg;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                acc_next = take;
                sat_next = item_reg.sample_present && !in_band;
                clr_next = take && gap_hit;
                cand_next = '0;
                if (take)
                begin
                    wpos_next = (wpos_eff == IDX_W'(WINDOW - 1))
                              ? '0 : wpos_eff + IDX_W'(1);
                    fill_next = (fill_eff < CNT_W'(WINDOW))
                              ? fill_eff + CNT_W'(1) : fill_eff;
                    last_time_next = item_reg.read_time_us;
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SCAN:
            begin
                if (rank_hit || cand_last)
                begin
                    median_next = cand_value;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cand_next = cand_reg + IDX_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (emit_ok)
                begin
                    result_next.median_value = median_reg;
                    result_next.accepted = acc_reg;
                    result_next.saturated = sat_reg;
                    result_next.window_cleared = clr_reg;
                    result_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            band_low_reg <= grmf_pkg::BAND_LOW_RST;
            band_high_reg <= grmf_pkg::BAND_HIGH_RST;
            gap_limit_reg <= grmf_pkg::GAP_LIMIT_RST;
            wpos_reg <= '0;
            fill_reg <= '0;
            last_time_reg <= '0;
            median_reg <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            band_low_reg <= band_low_next;
            band_high_reg <= band_high_next;
            gap_limit_reg <= gap_limit_next;
            wpos_reg <= wpos_next;
            fill_reg <= fill_next;
            last_time_reg <= last_time_next;
            median_reg <= median_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (sample_valid && !sample_stall)
        begin
            item_reg <= sample;
        end
        if (write_en)
        begin
            entries_reg[wpos_eff] <= item_reg.raw_sample;
        end
        cand_reg <= cand_next;
        acc_reg <= acc_next;
        sat_reg <= sat_next;
        clr_reg <= clr_next;
        result_reg <= result_next;
    end

    // fill count and write pointer stay inside the window
    `GRMF_ASSERT_NOW(a_fill_range, 1'b1, fill_reg <= CNT_W'(WINDOW), "fill count above window")
    `GRMF_ASSERT_NOW(a_wpos_range, 1'b1, wpos_reg <= IDX_W'(WINDOW - 1), "write pointer out of range")
    // the median must be found by the last filled candidate
    `GRMF_ASSERT_NOW(a_scan_hit, (state_reg == ST_SCAN) && cand_last, rank_hit, "no median rank found")
    // a cleared window always goes with an accepted sample, never with saturation
    `GRMF_ASSERT_NOW(a_flags, result_valid_reg, !(result_reg.window_cleared && !result_reg.accepted) && !(result_reg.accepted && result_reg.saturated), "inconsistent result flags")
    // a result appears only after the emit step
    `GRMF_ASSERT_NEXT(a_emit_src, !result_valid_reg && (state_reg != ST_EMIT), !result_valid_reg, "result without emit")

endmodule
